/* rtl/assert_macros.svh */
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge outside reset
`define LFBP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lfbp_pkg.sv */
// shared types and constants of the log field byte packer
package lfbp_pkg;

   localparam int MaxBytes = 13;
   localparam int CntW     = 4;
   localparam int NumLanes = 4;

   localparam logic [1:0] KIND_UVAR = 2'd0;
   localparam logic [1:0] KIND_SVAR = 2'd1;
   localparam logic [1:0] KIND_TAG2 = 2'd2;
   localparam logic [1:0] KIND_TAG8 = 2'd3;

   // tag2 levels, equal to the two tag bits of the first byte
   localparam logic [1:0] TAG2_BITS2 = 2'd0;
   localparam logic [1:0] TAG2_BITS4 = 2'd1;
   localparam logic [1:0] TAG2_BITS6 = 2'd2;
   localparam logic [1:0] TAG2_WIDE  = 2'd3;

   // tag8 field classes
   localparam logic [1:0] CLS_ZERO   = 2'd0;
   localparam logic [1:0] CLS_NIBBLE = 2'd1;
   localparam logic [1:0] CLS_BYTE   = 2'd2;
   localparam logic [1:0] CLS_HALF   = 2'd3;

   typedef logic [MaxBytes-1:0][7:0] byte_buf_type;
   typedef logic [NumLanes-1:0][31:0] value_vec_type;

   // what one lane finds about its value
   typedef struct packed {
      logic [1:0] lvl2;  // tag2 level: 0 fits 2b, 1 fits 4b, 2 fits 6b, 3 wider
      logic [1:0] code3; // tag2 size code: bytes minus one
      logic [1:0] cls8;  // tag8 class before pair cleanup
   } lane_info_type;

   typedef lane_info_type [NumLanes-1:0] lane_vec_type;

endpackage

/* rtl/lfbp_if.sv */
// request and response channel interfaces of the packer
interface lfbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] value_a;
   logic [31:0] value_b;
   logic [31:0] value_c;
   logic [31:0] value_d;

   modport source (output valid, kind, value_a, value_b, value_c, value_d, input ready);
   modport sink   (input valid, kind, value_a, value_b, value_c, value_d, output ready);
endinterface

interface lfbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

/* rtl/lfbp_lane.sv */
// one classification lane: range checks of a single 32-bit value
module lfbp_lane (
   input  logic [31:0]             value,
   output lfbp_pkg::lane_info_type info
);
   import lfbp_pkg::*;

   logic fit2, fit4, fit6, fit8, fit16, fit24;

   // a value fits n signed bits when bits 31 down to n-1 all agree
   assign fit2  = (&value[31:1])  | ~(|value[31:1]);
   assign fit4  = (&value[31:3])  | ~(|value[31:3]);
   assign fit6  = (&value[31:5])  | ~(|value[31:5]);
   assign fit8  = (&value[31:7])  | ~(|value[31:7]);
   assign fit16 = (&value[31:15]) | ~(|value[31:15]);
   assign fit24 = (&value[31:23]) | ~(|value[31:23]);

   always_comb begin
      if (fit2)      info.lvl2 = TAG2_BITS2;
      else if (fit4) info.lvl2 = TAG2_BITS4;
      else if (fit6) info.lvl2 = TAG2_BITS6;
      else           info.lvl2 = TAG2_WIDE;

      if (fit8)       info.code3 = 2'd0;
      else if (fit16) info.code3 = 2'd1;
      else if (fit24) info.code3 = 2'd2;
      else            info.code3 = 2'd3;

      if (value == 32'd0) info.cls8 = CLS_ZERO;
      else if (fit4)      info.cls8 = CLS_NIBBLE;
      else if (fit8)      info.cls8 = CLS_BYTE;
      else                info.cls8 = CLS_HALF;
   end
endmodule

/* rtl/lfbp_merge.sv */
// merging stage: combines lane results into the byte string of one request
module lfbp_merge (
   input  logic [1:0]                 kind,
   input  lfbp_pkg::value_vec_type    values,
   input  lfbp_pkg::lane_vec_type     lanes,
   output lfbp_pkg::byte_buf_type     bytes,
   output logic [lfbp_pkg::CntW-1:0]  count
);
   import lfbp_pkg::*;

   logic [31:0]                uval;
   logic [4:0][7:0]            vbyte;
   logic [2:0]                 vlen;
   logic [1:0]                 tag;
   logic [3:0][1:0]            cls;
   logic [7:0]                 hdr;
   logic [3:0][3:0][7:0]       fb;
   logic [3:0][2:0]            fl;
   logic [CntW-1:0]            pos;
   logic [CntW-1:0]            slot;

   // varint of value a, zigzag mapped for the signed kind
   always_comb begin
      uval = (kind == KIND_SVAR) ? ({values[0][30:0], 1'b0} ^ {32{values[0][31]}})
                                 : values[0];
      if (uval[31:28] != 4'd0)      vlen = 3'd5;
      else if (uval[27:21] != 7'd0) vlen = 3'd4;
      else if (uval[20:14] != 7'd0) vlen = 3'd3;
      else if (uval[13:7] != 7'd0)  vlen = 3'd2;
      else                          vlen = 3'd1;
      for (int i = 0; i < 4; i++) begin
         vbyte[i] = {(3'(i) < vlen - 3'd1), uval[7*i +: 7]};
      end
      vbyte[4] = {4'd0, uval[31:28]};
   end

   // tag2 picks the widest level any field needs
   always_comb begin
      tag = lanes[0].lvl2;
      if (lanes[1].lvl2 > tag) tag = lanes[1].lvl2;
      if (lanes[2].lvl2 > tag) tag = lanes[2].lvl2;
   end

   // tag8 pair cleanup: an unpaired nibble field goes to a full byte
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         cls[2*p]   = lanes[2*p].cls8;
         cls[2*p+1] = lanes[2*p+1].cls8;
         if (lanes[2*p].cls8 == CLS_NIBBLE && lanes[2*p+1].cls8 != CLS_NIBBLE)
            cls[2*p] = CLS_BYTE;
         if (lanes[2*p+1].cls8 == CLS_NIBBLE && lanes[2*p].cls8 != CLS_NIBBLE)
            cls[2*p+1] = CLS_BYTE;
      end
   end

   // header byte plus up to four field groups of up to four bytes
   always_comb begin
      hdr = 8'd0;
      fb  = '0;
      fl  = '0;
      unique case (kind) inside
         KIND_UVAR, KIND_SVAR: begin
            hdr   = vbyte[0];
            fb[0] = {vbyte[4], vbyte[3], vbyte[2], vbyte[1]};
            fl[0] = vlen - 3'd1;
         end
         KIND_TAG2: begin
            unique case (tag)
               TAG2_BITS2: begin
                  hdr = {TAG2_BITS2, values[0][1:0], values[1][1:0], values[2][1:0]};
               end
               TAG2_BITS4: begin
                  hdr      = {TAG2_BITS4, 2'b00, values[0][3:0]};
                  fb[1][0] = {values[1][3:0], values[2][3:0]};
                  fl[1]    = 3'd1;
               end
               TAG2_BITS6: begin
                  hdr      = {TAG2_BITS6, values[0][5:0]};
                  fb[1][0] = values[1][7:0];
                  fb[2][0] = values[2][7:0];
                  fl[1]    = 3'd1;
                  fl[2]    = 3'd1;
               end
               default: begin
                  hdr = {TAG2_WIDE, lanes[2].code3, lanes[1].code3, lanes[0].code3};
                  for (int i = 0; i < 3; i++) begin
                     fb[i] = values[i];
                     fl[i] = {1'b0, lanes[i].code3} + 3'd1;
                  end
               end
            endcase
         end
         default: begin
            hdr = {cls[3], cls[2], cls[1], cls[0]};
            for (int p = 0; p < 2; p++) begin
               if (cls[2*p] == CLS_NIBBLE) begin
                  fb[2*p][0] = {values[2*p+1][3:0], values[2*p][3:0]};
                  fl[2*p]    = 3'd1;
               end else begin
                  for (int k = 0; k < 2; k++) begin
                     fb[2*p+k][1:0] = values[2*p+k][15:0];
                     unique case (cls[2*p+k])
                        CLS_BYTE: fl[2*p+k] = 3'd1;
                        CLS_HALF: fl[2*p+k] = 3'd2;
                        default:  fl[2*p+k] = 3'd0;
                     endcase
                  end
               end
            end
         end
      endcase
   end

   // place the groups one after another behind the header
   always_comb begin
      bytes    = '0;
      bytes[0] = hdr;
      pos      = CntW'(1);
      slot     = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            slot = pos + CntW'(j);
            if (3'(j) < fl[i] && slot < CntW'(MaxBytes)) begin
               bytes[slot] = fb[i][j];
            end
         end
         pos = pos + CntW'(fl[i]);
      end
      count = pos;
   end
endmodule

/* rtl/log_field_byte_packer_core.sv */
// top level of the log field byte packer: lanes, merge and byte output
//
//  channel   dir  handshake     payload
//  req_ch    in   valid/ready   kind, value_a..value_d
//  rsp_ch    out  valid/ready   out_byte, last
//
// an accepted request waits in stage one and moves to the byte shifter once the
// shifter is free, and the shifter then offers its first byte.
// it gives one byte per cycle while rsp_ch is ready, 1 to 13 bytes in all.
// the byte shifter is the only rate limit; the next request is packed while
// the current one is still draining and follows its last byte with no gap.
// reset is synchronous and clears the two stage valids only; a stalled response
// holds its byte; requests stall while both stages are full and no last byte is taken.
module log_field_byte_packer_core (
   input logic       clock,
   input logic       reset,
   lfbp_req_if.sink  req_ch,
   lfbp_rsp_if.source rsp_ch
);
   import lfbp_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_kind_ff;
   value_vec_type       s1_val_ff;
   logic                s2_valid_ff, s2_valid_in;
   byte_buf_type        s2_buf_ff, s2_buf_in;
   logic [CntW-1:0]     s2_cnt_ff, s2_cnt_in;

   lane_vec_type        lanes;
   byte_buf_type        m_bytes;
   logic [CntW-1:0]     m_count;

   logic req_fire, rsp_fire, rsp_done, s2_free, s2_load;

   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign rsp_done = rsp_fire && rsp_ch.last;
   assign s2_free  = !s2_valid_ff || rsp_done;
   assign s2_load  = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid    = s2_valid_ff;
   assign rsp_ch.out_byte = s2_buf_ff[0];
   assign rsp_ch.last     = (s2_cnt_ff == CntW'(1));

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      lfbp_lane u_lane (
         .value (s1_val_ff[g]),
         .info  (lanes[g])
      );
   end

   lfbp_merge u_merge (
      .kind   (s1_kind_ff),
      .values (s1_val_ff),
      .lanes  (lanes),
      .bytes  (m_bytes),
      .count  (m_count)
   );

   assign s1_valid_in = req_fire || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_done);

   always_comb begin
      s2_buf_in = s2_buf_ff;
      s2_cnt_in = s2_cnt_ff;
      if (s2_load) begin
         s2_buf_in = m_bytes;
         s2_cnt_in = m_count;
      end else if (rsp_fire) begin
         s2_buf_in = s2_buf_ff >> 8;
         s2_cnt_in = s2_cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_ch.kind;
         s1_val_ff  <= {req_ch.value_d, req_ch.value_c, req_ch.value_b, req_ch.value_a};
      end
      s2_buf_ff <= s2_buf_in;
      s2_cnt_ff <= s2_cnt_in;
   end

`include "assert_macros.svh"

   `LFBP_ASSERT_NOW(a_cnt_range, clock, reset, s2_valid_ff,
      (s2_cnt_ff != '0) && (s2_cnt_ff <= CntW'(MaxBytes)), "byte count out of range")
   `LFBP_ASSERT_NEXT(a_drain_step, clock, reset, rsp_fire && !rsp_ch.last,
      s2_valid_ff && (s2_cnt_ff == $past(s2_cnt_ff) - CntW'(1)),
      "request lost bytes while draining")
   `LFBP_ASSERT_NOW(a_stall_cause, clock, reset, !req_ch.ready,
      s1_valid_ff && s2_valid_ff && !rsp_done, "request stalled with room free")

endmodule
